// ===== rtl/bmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared constants and types for the bus memory map decoder: access kinds,
// fixed addresses, window bases, read-select codes and the decode struct.
// ----------------------------------------------------------------------------
package bmmd_pkg;

   // access kinds carried in the mode field
   localparam logic [1:0] MODE_BYTE_RD = 2'd0;
   localparam logic [1:0] MODE_WORD_RD = 2'd1;
   localparam logic [1:0] MODE_BYTE_WR = 2'd2;
   localparam logic [1:0] MODE_WORD_WR = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_DIP_ONE = 2'd0;
   localparam logic [1:0] REG_DIP_TWO = 2'd1;
   localparam logic [1:0] REG_SERVICE = 2'd2;

   localparam logic [7:0]  DIP_ONE_RESET = 8'hFE;
   localparam logic [7:0]  DIP_TWO_RESET = 8'hFF;
   localparam logic [15:0] SERVICE_RESET = 16'h0000;

   // exact-match addresses
   localparam logic [31:0] ADDR_DIP_ONE   = 32'h0039_0009;
   localparam logic [31:0] ADDR_DIP_TWO   = 32'h0039_000B;
   localparam logic [31:0] ADDR_LATCH_3E1 = 32'h003E_0001;
   localparam logic [31:0] ADDR_LATCH_3E3 = 32'h003E_0003;
   localparam logic [31:0] ADDR_SERVICE   = 32'h0005_FF9E;
   localparam logic [31:0] ADDR_LATCH_3C0 = 32'h003C_0000;
   localparam logic [31:0] ADDR_LATCH_C50 = 32'h00C5_0000;
   localparam logic [31:0] ADDR_LATCH_D01 = 32'h00D0_1BFE;
   localparam logic [31:0] ADDR_LATCH_350 = 32'h0035_0008;
   localparam logic [31:0] ADDR_LATCH_380 = 32'h0038_0000;

   // ram windows, each aligned to its own size
   localparam int NUM_WIN = 6;
   localparam int WIN_MAIN = 0;
   localparam int WIN_WORK = 1;
   localparam int WIN_TXT_A = 2;
   localparam int WIN_TXT_B = 3;
   localparam int WIN_TXT_C = 4;
   localparam int WIN_TXT_D = 5;

   localparam logic [31:0] BASE_MAIN  = 32'h0020_0000;
   localparam logic [31:0] BASE_WORK  = 32'h0010_C000;
   localparam logic [31:0] BASE_TXT_A = 32'h00C0_0000;
   localparam logic [31:0] BASE_TXT_B = 32'h00C0_8000;
   localparam logic [31:0] BASE_TXT_C = 32'h00C0_4000;
   localparam logic [31:0] BASE_TXT_D = 32'h00C0_C000;

   // word-index widths of the windows (8192, 2048 and 4096 words)
   localparam int AW_MAIN = 13;
   localparam int AW_TXT_AB = 11;
   localparam int AW_TXT_CD = 12;

   // clearing pass covers the deepest window
   localparam int CLR_CNT_WIDTH = AW_MAIN;

   // read-select codes
   localparam logic [2:0] RD_ZERO    = 3'd0;
   localparam logic [2:0] RD_DIP_ONE = 3'd1;
   localparam logic [2:0] RD_DIP_TWO = 3'd2;
   localparam logic [2:0] RD_LATCH_B = 3'd3;
   localparam logic [2:0] RD_SERVICE = 3'd4;
   localparam logic [2:0] RD_LATCH_W = 3'd5;
   localparam logic [2:0] RD_WINDOW  = 3'd6;

   typedef struct packed {
      logic [2:0]         rd_sel;
      logic [NUM_WIN-1:0] win_hit;
      logic               win_wr_hi;
      logic               win_wr_lo;
      logic               latch_b_we;
      logic               latch_w_we;
      logic               byte_acc;
      logic               odd;
   } dec_type;

endpackage

// ===== rtl/bmmd_decode.sv =====
// ----------------------------------------------------------------------------
// bmmd_decode
// Address decode: exact-match registers and latches first, then the six
// word ram windows, qualified by the access kind.
// ----------------------------------------------------------------------------
module bmmd_decode (
   input  logic [1:0]       mode,
   input  logic [31:0]      address,
   output bmmd_pkg::dec_type dec
);

   logic [bmmd_pkg::NUM_WIN-1:0] win_hit;
   logic                         any_win;

   // windows never overlap, so each compare stands alone
   assign win_hit[bmmd_pkg::WIN_MAIN]  = address[31:14] == bmmd_pkg::BASE_MAIN[31:14];
   assign win_hit[bmmd_pkg::WIN_WORK]  = address[31:14] == bmmd_pkg::BASE_WORK[31:14];
   assign win_hit[bmmd_pkg::WIN_TXT_A] = address[31:12] == bmmd_pkg::BASE_TXT_A[31:12];
   assign win_hit[bmmd_pkg::WIN_TXT_B] = address[31:12] == bmmd_pkg::BASE_TXT_B[31:12];
   assign win_hit[bmmd_pkg::WIN_TXT_C] = address[31:13] == bmmd_pkg::BASE_TXT_C[31:13];
   assign win_hit[bmmd_pkg::WIN_TXT_D] = address[31:13] == bmmd_pkg::BASE_TXT_D[31:13];
   assign any_win = |win_hit;

   always_comb begin
      dec            = '0;
      dec.win_hit    = win_hit;
      dec.byte_acc   = ~mode[0];
      dec.odd        = address[0];
      dec.rd_sel     = bmmd_pkg::RD_ZERO;
      unique case (mode)
         bmmd_pkg::MODE_BYTE_RD: begin
            priority if (address == bmmd_pkg::ADDR_DIP_ONE) begin
               dec.rd_sel = bmmd_pkg::RD_DIP_ONE;
            end else if (address == bmmd_pkg::ADDR_DIP_TWO) begin
               dec.rd_sel = bmmd_pkg::RD_DIP_TWO;
            end else if (address == bmmd_pkg::ADDR_LATCH_3E3) begin
               dec.rd_sel = bmmd_pkg::RD_LATCH_B;
            end else if (any_win) begin
               dec.rd_sel = bmmd_pkg::RD_WINDOW;
            end else begin
               dec.rd_sel = bmmd_pkg::RD_ZERO;
            end
         end
         bmmd_pkg::MODE_WORD_RD: begin
            priority if (address == bmmd_pkg::ADDR_SERVICE) begin
               dec.rd_sel = bmmd_pkg::RD_SERVICE;
            end else if (address == bmmd_pkg::ADDR_LATCH_3C0) begin
               dec.rd_sel = bmmd_pkg::RD_LATCH_W;
            end else if (any_win) begin
               dec.rd_sel = bmmd_pkg::RD_WINDOW;
            end else begin
               dec.rd_sel = bmmd_pkg::RD_ZERO;
            end
         end
         bmmd_pkg::MODE_BYTE_WR: begin
            // write-only latch at 3e0001 has no readback, the beat is absorbed
            priority if (address == bmmd_pkg::ADDR_LATCH_3E1) begin
               dec.latch_b_we = 1'b0;
            end else if (address == bmmd_pkg::ADDR_LATCH_3E3) begin
               dec.latch_b_we = 1'b1;
            end else begin
               dec.win_wr_hi = ~address[0];
               dec.win_wr_lo = address[0];
            end
         end
         bmmd_pkg::MODE_WORD_WR: begin
            // write-only latches: absorbed, nothing can read them back
            priority if (address == bmmd_pkg::ADDR_LATCH_C50 ||
                          address == bmmd_pkg::ADDR_LATCH_D01 ||
                          address == bmmd_pkg::ADDR_LATCH_350 ||
                          address == bmmd_pkg::ADDR_LATCH_380) begin
               dec.latch_w_we = 1'b0;
            end else if (address == bmmd_pkg::ADDR_LATCH_3C0) begin
               dec.latch_w_we = 1'b1;
            end else begin
               dec.win_wr_hi = 1'b1;
               dec.win_wr_lo = 1'b1;
            end
         end
         default: begin
            dec.rd_sel = bmmd_pkg::RD_ZERO;
         end
      endcase
   end

endmodule

// ===== rtl/bmmd_ram.sv =====
// ----------------------------------------------------------------------------
// bmmd_ram
// Word ram split into high and low byte lanes with separate write enables;
// one address per cycle, registered read data.
// ----------------------------------------------------------------------------
module bmmd_ram #(
   parameter int ADDR_WIDTH = 13
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic                  we_hi,
   input  logic                  we_lo,
   input  logic [ADDR_WIDTH-1:0] addr,
   input  logic [7:0]            wdata_hi,
   input  logic [7:0]            wdata_lo,
   output logic [15:0]           rdata
);

   localparam int DEPTH = 2 ** ADDR_WIDTH;

   logic [7:0]  hi_mem_ff [DEPTH];
   logic [7:0]  lo_mem_ff [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we_hi) begin
         hi_mem_ff[addr] <= wdata_hi;
      end
      if (we_lo) begin
         lo_mem_ff[addr] <= wdata_lo;
      end
      if (rd_en) begin
         rdata_ff <= {hi_mem_ff[addr], lo_mem_ff[addr]};
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bus_memory_map_decoder.sv =====
// ----------------------------------------------------------------------------
// bus_memory_map_decoder
// Decodes byte and word bus accesses onto DIP banks, a service word, two
// readable latches and six word ram windows.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)                          | notes
//  req     | in  | mode[1:0], address[33:2], write_data[49:34], pad  | one beat per access
//  rsp     | out | read_data[15:0]                                   | one beat per req beat
//  csr     | in  | csr_index selects register, csr_data value        | always ready
//
// One access per cycle while no rsp beat is stalled; a response passes the input register,
// the ram read register and the result register before rsp_tvalid rises.
// After reset a clearing pass zeroes all rams, with req_tready low.
// A stalled rsp beat freezes the whole pipeline and drops req_tready.
// ----------------------------------------------------------------------------
module bus_memory_map_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // mode[1:0], address[33:2], write_data[49:34], zero[55:50]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int NW = bmmd_pkg::NUM_WIN;

   // configuration
   logic [7:0]  dip_one_ff;
   logic [7:0]  dip_two_ff;
   logic [15:0] service_ff;

   // readable latches
   logic [7:0]  latch_b_ff;
   logic [15:0] latch_w_ff;

   // clearing pass
   logic                              clearing_ff;
   logic [bmmd_pkg::CLR_CNT_WIDTH-1:0] clr_cnt_ff;
   logic [bmmd_pkg::CLR_CNT_WIDTH-1:0] clr_cnt_in;

   // pipeline
   logic        adv;
   logic        req_fire;
   logic        act;
   logic        s1_valid_ff;
   logic [1:0]  s1_mode_ff;
   logic [31:0] s1_addr_ff;
   logic [15:0] s1_wdata_ff;
   bmmd_pkg::dec_type dec;
   logic [15:0] imm_value;

   logic          s2_valid_ff;
   logic [2:0]    s2_sel_ff;
   logic [NW-1:0] s2_hit_ff;
   logic          s2_byte_ff;
   logic          s2_odd_ff;
   logic [15:0]   s2_imm_ff;

   logic [15:0] ram_rdata [NW];
   logic [15:0] win_word;
   logic [15:0] rsp_data_in;
   logic [15:0] rsp_data_ff;
   logic        rsp_valid_ff;

   logic [7:0]  wr_hi_byte;

   assign adv        = ~rsp_valid_ff | rsp_tready;
   assign req_tready = adv & ~clearing_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign act        = adv & s1_valid_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_one_ff <= bmmd_pkg::DIP_ONE_RESET;
         dip_two_ff <= bmmd_pkg::DIP_TWO_RESET;
         service_ff <= bmmd_pkg::SERVICE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmmd_pkg::REG_DIP_ONE: dip_one_ff <= csr_data[7:0];
            bmmd_pkg::REG_DIP_TWO: dip_two_ff <= csr_data[7:0];
            bmmd_pkg::REG_SERVICE: service_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_in;
         if (&clr_cnt_ff) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_tdata[1:0];
         s1_addr_ff  <= req_tdata[33:2];
         s1_wdata_ff <= req_tdata[49:34];
      end
   end

   bmmd_decode u_decode (
      .mode    (s1_mode_ff),
      .address (s1_addr_ff),
      .dec     (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_b_ff <= '0;
         latch_w_ff <= '0;
      end else if (act) begin
         if (dec.latch_b_we) begin
            latch_b_ff <= s1_wdata_ff[7:0];
         end
         if (dec.latch_w_we) begin
            latch_w_ff <= s1_wdata_ff;
         end
      end
   end

   always_comb begin
      unique case (dec.rd_sel)
         bmmd_pkg::RD_DIP_ONE: imm_value = {8'h00, dip_one_ff};
         bmmd_pkg::RD_DIP_TWO: imm_value = {8'h00, dip_two_ff};
         bmmd_pkg::RD_LATCH_B: imm_value = {8'h00, latch_b_ff};
         bmmd_pkg::RD_SERVICE: imm_value = service_ff;
         bmmd_pkg::RD_LATCH_W: imm_value = latch_w_ff;
         default:              imm_value = 16'h0000;
      endcase
   end

   // a byte write lands in either lane from the low data byte
   assign wr_hi_byte = dec.byte_acc ? s1_wdata_ff[7:0] : s1_wdata_ff[15:8];

   for (genvar g = 0; g < NW; g++) begin : g_win
      localparam int AW = (g == bmmd_pkg::WIN_MAIN || g == bmmd_pkg::WIN_WORK) ?
                          bmmd_pkg::AW_MAIN :
                          (g == bmmd_pkg::WIN_TXT_A || g == bmmd_pkg::WIN_TXT_B) ?
                          bmmd_pkg::AW_TXT_AB : bmmd_pkg::AW_TXT_CD;
      logic [AW-1:0] ram_addr;
      logic          we_hi;
      logic          we_lo;
      logic [7:0]    wd_hi;
      logic [7:0]    wd_lo;

      assign ram_addr = clearing_ff ? clr_cnt_ff[AW-1:0] : s1_addr_ff[AW:1];
      assign we_hi    = clearing_ff | (act & dec.win_hit[g] & dec.win_wr_hi);
      assign we_lo    = clearing_ff | (act & dec.win_hit[g] & dec.win_wr_lo);
      assign wd_hi    = clearing_ff ? 8'h00 : wr_hi_byte;
      assign wd_lo    = clearing_ff ? 8'h00 : s1_wdata_ff[7:0];

      bmmd_ram #(
         .ADDR_WIDTH (AW)
      ) u_ram (
         .clock    (clock),
         .rd_en    (adv),
         .we_hi    (we_hi),
         .we_lo    (we_lo),
         .addr     (ram_addr),
         .wdata_hi (wd_hi),
         .wdata_lo (wd_lo),
         .rdata    (ram_rdata[g])
      );
   end

   // stage 2 runs alongside the ram read register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sel_ff  <= dec.rd_sel;
         s2_hit_ff  <= dec.win_hit;
         s2_byte_ff <= dec.byte_acc;
         s2_odd_ff  <= dec.odd;
         s2_imm_ff  <= imm_value;
      end
   end

   always_comb begin
      win_word = 16'h0000;
      for (int i = 0; i < NW; i++) begin
         win_word = win_word | (ram_rdata[i] & {16{s2_hit_ff[i]}});
      end
   end

   always_comb begin
      if (s2_sel_ff == bmmd_pkg::RD_WINDOW) begin
         if (!s2_byte_ff) begin
            rsp_data_in = win_word;
         end else if (s2_odd_ff) begin
            rsp_data_in = {8'h00, win_word[7:0]};
         end else begin
            rsp_data_in = {8'h00, win_word[15:8]};
         end
      end else begin
         rsp_data_in = s2_imm_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/bmmd_checker.sv =====
// ----------------------------------------------------------------------------
// bmmd_checker
// Port-level checks on the decoder: reset behavior, stall hold and the
// zero response of write beats.
// ----------------------------------------------------------------------------
module bmmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // the clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   // with the output side open, a write beat comes back as a zero response
   a_write_returns_zero: assert property (@(posedge clock) disable iff (reset)
      $past(req_tvalid && req_tready && req_tdata[1], 3) &&
      $past(rsp_tready, 1) && $past(rsp_tready, 2) &&
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
      |-> rsp_tvalid && rsp_tdata == 16'h0000)
      else $error("write beat did not return zero");

endmodule

bind bus_memory_map_decoder bmmd_checker u_bmmd_checker (.*);
